// ===== design/hdt_pkg.sv =====
// ----------------------------------------------------------------------------
// hdt_pkg: shared types and constants of the HPACK dynamic table core
// Request and response word layouts, request, status and hit codes.
// ----------------------------------------------------------------------------
package hdt_pkg;

   localparam int STORE_BYTES_DEF = 4096;
   localparam int MAX_ENTRIES_DEF = 128;
   localparam int ENTRY_OVERHEAD  = 32;
   localparam int STATIC_COUNT    = 61;
   localparam int PEND_W          = 17;

   localparam logic [2:0] REQ_LOOKUP    = 3'd0;
   localparam logic [2:0] REQ_ADD_BEGIN = 3'd1;
   localparam logic [2:0] REQ_ADD_DATA  = 3'd2;
   localparam logic [2:0] REQ_SIZE_UPD  = 3'd3;
   localparam logic [2:0] REQ_READ_BYTE = 3'd4;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_ERROR    = 2'd1;
   localparam logic [1:0] STATUS_DECLINED = 2'd2;

   localparam logic [1:0] HIT_NONE    = 2'd0;
   localparam logic [1:0] HIT_STATIC  = 2'd1;
   localparam logic [1:0] HIT_DYNAMIC = 2'd2;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [7:0]  hpack_index;
      logic        skip_value;
      logic [15:0] name_length;
      logic [15:0] value_length;
      logic [7:0]  data_byte;
      logic [15:0] new_size;
      logic [11:0] read_addr;
   } hdt_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  hit_kind;
      logic [5:0]  static_index;
      logic [11:0] name_offset;
      logic [11:0] name_len_out;
      logic [11:0] value_offset;
      logic [11:0] value_len_out;
      logic [7:0]  read_data;
      logic [7:0]  entry_count;
      logic [12:0] free_bytes;
   } hdt_rsp_type;

endpackage

// ===== design/hdt_ram.sv =====
// ----------------------------------------------------------------------------
// hdt_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/hpack_dynamic_table_core.sv =====
// ----------------------------------------------------------------------------
// hpack_dynamic_table_core: HPACK dynamic header table
// Circular byte store plus a ring of entry descriptors, with eviction.
// ----------------------------------------------------------------------------
// A request word is taken at a clock edge where start is high and busy is
// low. Every request gives one response word on rsp_word, shown for exactly
// one cycle with rsp_strobe high; the receiver cannot stall it.
// Response path from accept to strobe:
//   data byte, static or bad lookup, declined add, size grow, errors: direct
//   dynamic lookup, read byte: through a wait state (one registered RAM read)
//   add begin, size shrink: through the check state; each eviction reads the
//   oldest descriptor from the ring RAM and then frees its space.
// busy is high from the accept until the response cycle, never for a direct
// response, and a new word may be accepted in the response cycle.
// Reset empties the table: no live entries, table and free space equal to
// the store size, no bytes pending. RAM contents are not cleared; a byte or
// descriptor never written reads back as garbage.
// ----------------------------------------------------------------------------
module hpack_dynamic_table_core #(
   parameter int STORE_BYTES = hdt_pkg::STORE_BYTES_DEF,
   parameter int MAX_ENTRIES = hdt_pkg::MAX_ENTRIES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  hdt_pkg::hdt_req_type req_word,
   output logic                rsp_strobe,
   output hdt_pkg::hdt_rsp_type rsp_word
);

   localparam int AW = $clog2(STORE_BYTES);
   localparam int DW = 3 * AW;
   localparam int SW = $clog2(STORE_BYTES + 1);
   localparam int EW = $clog2(MAX_ENTRIES);
   localparam int LW = $clog2(MAX_ENTRIES + 1);
   localparam int PW = hdt_pkg::PEND_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK_WAIT,
      ST_READ_WAIT,
      ST_EV_CHECK,
      ST_EV_WAIT
   } state_type;

   state_type            state_ff, state_in;
   logic [EW-1:0]        oldest_ff, oldest_in;
   logic [LW-1:0]        live_ff, live_in;
   logic [AW-1:0]        wp_ff, wp_in;
   logic [SW-1:0]        table_ff, table_in;
   logic [SW-1:0]        free_ff, free_in;
   logic [PW-1:0]        pend_ff, pend_in;
   logic                 discard_ff, discard_in;
   logic [SW-1:0]        need_ff, need_in;
   logic                 add_mode_ff, add_mode_in;
   logic [AW-1:0]        nlen_ff, nlen_in;
   logic [AW-1:0]        vlen_ff, vlen_in;
   logic                 nonly_ff, nonly_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   hdt_pkg::hdt_rsp_type rsp_ff, rsp_in;

   logic                 accept;
   logic [31:0]          total32, size32, skip32, wp_skip32, wp_inc32;
   logic [31:0]          idx32, dyn32, look32, tail32, raddr32, nsize32;
   logic                 dyn_hit;
   logic [31:0]          e_noff32, e_nlen32, e_vlen32, voff32, ev_free32;
   logic [31:0]          oldest_inc32, fit_free32, grow32, sidx32;
   logic [31:0]          cnt32, free32;
   logic                 ev_go;

   logic                 byte_we;
   logic [AW-1:0]        byte_raddr;
   logic [7:0]           byte_rdata;
   logic                 ring_we;
   logic [EW-1:0]        ring_waddr, ring_raddr;
   logic [DW-1:0]        ring_wdata, ring_rdata;

   hdt_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_byte_store (
      .clock   (clock),
      .wr_en   (byte_we),
      .wr_addr (wp_ff),
      .wr_data (req_word.data_byte),
      .rd_addr (byte_raddr),
      .rd_data (byte_rdata)
   );

   hdt_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_ENTRIES)
   ) u_entry_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_waddr),
      .wr_data (ring_wdata),
      .rd_addr (ring_raddr),
      .rd_data (ring_rdata)
   );

   assign accept = start && (state_ff == ST_IDLE);

   always_comb begin
      total32 = 32'(req_word.name_length) + 32'(req_word.value_length);
      size32  = total32 + 32'(hdt_pkg::ENTRY_OVERHEAD);

      skip32 = 32'(wp_ff) + 32'(pend_ff);
      if (skip32 >= 32'(STORE_BYTES)) begin
         wp_skip32 = skip32 - 32'(STORE_BYTES);
      end else begin
         wp_skip32 = skip32;
      end

      wp_inc32 = 32'(wp_ff) + 32'd1;
      if (wp_inc32 >= 32'(STORE_BYTES)) begin
         wp_inc32 = 32'd0;
      end

      idx32   = 32'(req_word.hpack_index);
      sidx32  = idx32 - 32'd1;
      dyn32   = idx32 - 32'(hdt_pkg::STATIC_COUNT + 1);
      dyn_hit = (idx32 > 32'(hdt_pkg::STATIC_COUNT)) && (dyn32 < 32'(live_ff));
      look32  = 32'(oldest_ff) + 32'(live_ff) - 32'd1 - dyn32;
      if (look32 >= 32'(MAX_ENTRIES)) begin
         look32 = look32 - 32'(MAX_ENTRIES);
      end

      tail32 = 32'(oldest_ff) + 32'(live_ff);
      if (tail32 >= 32'(MAX_ENTRIES)) begin
         tail32 = tail32 - 32'(MAX_ENTRIES);
      end

      oldest_inc32 = 32'(oldest_ff) + 32'd1;
      if (oldest_inc32 >= 32'(MAX_ENTRIES)) begin
         oldest_inc32 = 32'd0;
      end

      raddr32 = 32'(req_word.read_addr);
      for (int k = 3; k >= 0; k--) begin
         if (raddr32 >= (32'(STORE_BYTES) << k)) begin
            raddr32 = raddr32 - (32'(STORE_BYTES) << k);
         end
      end

      nsize32 = 32'(req_word.new_size);
      grow32  = 32'(free_ff) + nsize32 - 32'(table_ff);

      e_noff32 = 32'(ring_rdata[DW-1 -: AW]);
      e_nlen32 = 32'(ring_rdata[2*AW-1 -: AW]);
      e_vlen32 = 32'(ring_rdata[AW-1:0]);
      voff32   = e_noff32 + e_nlen32;
      if (voff32 >= 32'(STORE_BYTES)) begin
         voff32 = voff32 - 32'(STORE_BYTES);
      end
      ev_free32 = 32'(free_ff) + 32'(hdt_pkg::ENTRY_OVERHEAD) + e_nlen32 + e_vlen32;

      if (32'(need_ff) <= 32'(free_ff)) begin
         fit_free32 = 32'(free_ff) - 32'(need_ff);
      end else begin
         fit_free32 = 32'd0;
      end

      ev_go = ((32'(need_ff) > 32'(free_ff)) && (live_ff != '0)) ||
              (add_mode_ff && (32'(live_ff) >= 32'(MAX_ENTRIES)));
   end

   assign byte_we    = accept && (req_word.req_type == hdt_pkg::REQ_ADD_DATA) &&
                       (pend_ff != '0) && !discard_ff;
   assign byte_raddr = raddr32[AW-1:0];
   assign ring_raddr = (state_ff == ST_IDLE) ? look32[EW-1:0] : oldest_ff;
   assign ring_we    = (state_ff == ST_EV_CHECK) && !ev_go && add_mode_ff;
   assign ring_waddr = tail32[EW-1:0];
   assign ring_wdata = {wp_ff, nlen_ff, vlen_ff};

   always_comb begin
      state_in     = state_ff;
      oldest_in    = oldest_ff;
      live_in      = live_ff;
      wp_in        = wp_ff;
      table_in     = table_ff;
      free_in      = free_ff;
      pend_in      = pend_ff;
      discard_in   = discard_ff;
      need_in      = need_ff;
      add_mode_in  = add_mode_ff;
      nlen_in      = nlen_ff;
      vlen_in      = vlen_ff;
      nonly_in     = nonly_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_word.req_type)
                  hdt_pkg::REQ_LOOKUP: begin
                     nonly_in = req_word.skip_value;
                     if (idx32 == 32'd0) begin
                        rsp_in.status = hdt_pkg::STATUS_ERROR;
                        rsp_valid_in  = 1'b1;
                     end else if (idx32 <= 32'(hdt_pkg::STATIC_COUNT)) begin
                        rsp_in.hit_kind     = hdt_pkg::HIT_STATIC;
                        rsp_in.static_index = sidx32[5:0];
                        rsp_valid_in        = 1'b1;
                     end else if (dyn_hit) begin
                        state_in = ST_LOOK_WAIT;
                     end else begin
                        rsp_in.status = hdt_pkg::STATUS_ERROR;
                        rsp_valid_in  = 1'b1;
                     end
                  end
                  hdt_pkg::REQ_ADD_BEGIN: begin
                     if ((pend_ff != '0) && !discard_ff) begin
                        wp_in = wp_skip32[AW-1:0];
                     end
                     pend_in = total32[PW-1:0];
                     if (size32 > 32'(table_ff)) begin
                        oldest_in     = tail32[EW-1:0];
                        live_in       = '0;
                        free_in       = table_ff;
                        discard_in    = (total32 != 32'd0);
                        rsp_in.status = hdt_pkg::STATUS_DECLINED;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        discard_in  = 1'b0;
                        need_in     = size32[SW-1:0];
                        add_mode_in = 1'b1;
                        nlen_in     = req_word.name_length[AW-1:0];
                        vlen_in     = req_word.value_length[AW-1:0];
                        state_in    = ST_EV_CHECK;
                     end
                  end
                  hdt_pkg::REQ_ADD_DATA: begin
                     rsp_valid_in = 1'b1;
                     if (pend_ff == '0) begin
                        rsp_in.status = hdt_pkg::STATUS_ERROR;
                     end else begin
                        if (!discard_ff) begin
                           wp_in = wp_inc32[AW-1:0];
                        end
                        pend_in = pend_ff - PW'(1);
                        if (pend_ff == PW'(1)) begin
                           discard_in = 1'b0;
                        end
                     end
                  end
                  hdt_pkg::REQ_SIZE_UPD: begin
                     if (nsize32 > 32'(STORE_BYTES)) begin
                        rsp_in.status = hdt_pkg::STATUS_ERROR;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        table_in = nsize32[SW-1:0];
                        if (nsize32 < 32'(table_ff)) begin
                           need_in     = table_ff - nsize32[SW-1:0];
                           add_mode_in = 1'b0;
                           state_in    = ST_EV_CHECK;
                        end else begin
                           free_in      = grow32[SW-1:0];
                           rsp_valid_in = 1'b1;
                        end
                     end
                  end
                  hdt_pkg::REQ_READ_BYTE: begin
                     state_in = ST_READ_WAIT;
                  end
                  default: begin
                     rsp_in.status = hdt_pkg::STATUS_ERROR;
                     rsp_valid_in  = 1'b1;
                  end
               endcase
            end
         end
         ST_LOOK_WAIT: begin
            rsp_in.hit_kind     = hdt_pkg::HIT_DYNAMIC;
            rsp_in.name_offset  = e_noff32[11:0];
            rsp_in.name_len_out = e_nlen32[11:0];
            if (!nonly_ff) begin
               rsp_in.value_offset  = voff32[11:0];
               rsp_in.value_len_out = e_vlen32[11:0];
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_READ_WAIT: begin
            rsp_in.read_data = byte_rdata;
            rsp_valid_in     = 1'b1;
            state_in         = ST_IDLE;
         end
         ST_EV_CHECK: begin
            if (ev_go) begin
               state_in = ST_EV_WAIT;
            end else begin
               free_in = fit_free32[SW-1:0];
               if (add_mode_ff) begin
                  live_in = live_ff + LW'(1);
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_EV_WAIT: begin
            free_in   = ev_free32[SW-1:0];
            oldest_in = oldest_inc32[EW-1:0];
            live_in   = live_ff - LW'(1);
            state_in  = ST_EV_CHECK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         oldest_ff    <= '0;
         live_ff      <= '0;
         wp_ff        <= '0;
         table_ff     <= SW'(STORE_BYTES);
         free_ff      <= SW'(STORE_BYTES);
         pend_ff      <= '0;
         discard_ff   <= 1'b0;
         add_mode_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         live_ff      <= live_in;
         wp_ff        <= wp_in;
         table_ff     <= table_in;
         free_ff      <= free_in;
         pend_ff      <= pend_in;
         discard_ff   <= discard_in;
         add_mode_ff  <= add_mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      need_ff  <= need_in;
      nlen_ff  <= nlen_in;
      vlen_ff  <= vlen_in;
      nonly_ff <= nonly_in;
      rsp_ff   <= rsp_in;
   end

   assign cnt32  = 32'(live_ff);
   assign free32 = 32'(free_ff);

   always_comb begin
      rsp_word             = rsp_ff;
      rsp_word.entry_count = cnt32[7:0];
      rsp_word.free_bytes  = free32[12:0];
   end

   assign rsp_strobe = rsp_valid_ff;
   assign busy       = (state_ff != ST_IDLE);

   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      32'(live_ff) <= 32'(MAX_ENTRIES))
      else $error("live entry count beyond descriptor ring depth");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (free_ff <= table_ff))
      else $error("free space exceeds table size");

   a_discard_pend: assert property (@(posedge clock) disable iff (reset)
      discard_ff |-> (pend_ff != '0))
      else $error("discard flag set with no bytes pending");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) || $past(start)))
      else $error("response word with no request in flight");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the HPACK dynamic table core
// Feeds lookup, add, data byte, size update and read byte words through the
// start/busy handshake. A behavioral copy of the table predicts each response
// word unless a directed row gives its own; all are checked field by field.
// Directed table first, then random traffic, a descriptor ring fill, random again.
// ----------------------------------------------------------------------------
module tb_top;
   import hdt_pkg::*;

   localparam int STORE         = STORE_BYTES_DEF;
   localparam int SLOTS         = MAX_ENTRIES_DEF;
   localparam int IDX_FIRST_DYN = STATIC_COUNT + 1;
   localparam int DRAIN_CYCLES  = 300;

   localparam logic [2:0] REQ_RSVD_5 = 3'd5;
   localparam logic [2:0] REQ_RSVD_6 = 3'd6;
   localparam logic [2:0] REQ_RSVD_7 = 3'd7;

   typedef struct {
      hdt_req_type word;
      bit          typed;
      hdt_rsp_type rsp;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   hdt_req_type req_word;
   logic        rsp_strobe;
   hdt_rsp_type rsp_word;

   bit          row_typed;
   hdt_rsp_type row_rsp;
   bit          idle_on;

   stim_row_type directed_rows[$];
   hdt_rsp_type expected_rsp_words[$];

   // table image
   logic [7:0]  store_bytes[STORE];
   bit          store_known[STORE];
   int          known_addrs[$];
   int          ent_name_off[SLOTS];
   int          ent_name_len[SLOTS];
   int          ent_value_len[SLOTS];
   int          ring_head     = 0;
   int          live_cnt      = 0;
   int          wr_ptr        = 0;
   int          tbl_limit     = STORE;
   int          room          = STORE;
   int          left_to_store = 0;
   bit          dropping      = 1'b0;

   int          bytes_to_send = 0;
   int          fail_count    = 0;
   int          words_accepted = 0;
   int          dyn_hits      = 0;
   int          declined_adds = 0;
   int          error_rsps    = 0;
   int          evictions     = 0;
   int          peak_live     = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   hpack_dynamic_table_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   function automatic void drop_oldest();
      if (live_cnt != 0) begin
         room += ENTRY_OVERHEAD + ent_name_len[ring_head] + ent_value_len[ring_head];
         ring_head = (ring_head + 1) % SLOTS;
         live_cnt--;
         evictions++;
      end
   endfunction

   function automatic logic [1:0] open_entry(input int nlen, input int vlen);
      int total;
      int need;
      int slot;
      total = nlen + vlen;
      need  = total + ENTRY_OVERHEAD;
      // skip bytes abandoned by the previous add
      if (left_to_store != 0 && !dropping) wr_ptr = (wr_ptr + left_to_store) % STORE;
      left_to_store = 0;
      dropping = 1'b0;
      if (need > tbl_limit) begin
         ring_head = (ring_head + live_cnt) % SLOTS;
         live_cnt = 0;
         room = tbl_limit;
         left_to_store = total;
         dropping = (total != 0);
         return STATUS_DECLINED;
      end
      while (need > room && live_cnt != 0) drop_oldest();
      if (live_cnt >= SLOTS) drop_oldest();
      room = (need <= room) ? room - need : 0;
      slot = (ring_head + live_cnt) % SLOTS;
      ent_name_off[slot]  = wr_ptr;
      ent_name_len[slot]  = nlen;
      ent_value_len[slot] = vlen;
      live_cnt++;
      left_to_store = total;
      return STATUS_OK;
   endfunction

   function automatic hdt_rsp_type apply_to_table(input hdt_req_type w);
      hdt_rsp_type r;
      int idx;
      int d;
      int slot;
      int shrink;
      r = '0;
      idx = int'(w.hpack_index);
      case (w.req_type)
         REQ_LOOKUP: begin
            if (idx == 0) begin
               r.status = STATUS_ERROR;
            end else if (idx <= STATIC_COUNT) begin
               r.hit_kind = HIT_STATIC;
               r.static_index = 6'(idx - 1);
            end else begin
               d = idx - IDX_FIRST_DYN;
               if (d < live_cnt) begin
                  slot = (ring_head + live_cnt - 1 - d) % SLOTS;
                  r.hit_kind = HIT_DYNAMIC;
                  r.name_offset = 12'(ent_name_off[slot]);
                  r.name_len_out = 12'(ent_name_len[slot]);
                  if (!w.skip_value) begin
                     r.value_offset = 12'((ent_name_off[slot] + ent_name_len[slot]) % STORE);
                     r.value_len_out = 12'(ent_value_len[slot]);
                  end
               end else begin
                  r.status = STATUS_ERROR;
               end
            end
         end
         REQ_ADD_BEGIN: begin
            r.status = open_entry(int'(w.name_length), int'(w.value_length));
         end
         REQ_ADD_DATA: begin
            if (left_to_store == 0) begin
               r.status = STATUS_ERROR;
            end else begin
               if (!dropping) begin
                  store_bytes[wr_ptr] = w.data_byte;
                  if (!store_known[wr_ptr]) begin
                     store_known[wr_ptr] = 1'b1;
                     known_addrs.push_back(wr_ptr);
                  end
                  wr_ptr = (wr_ptr + 1) % STORE;
               end
               left_to_store--;
               if (left_to_store == 0) dropping = 1'b0;
            end
         end
         REQ_SIZE_UPD: begin
            if (int'(w.new_size) > STORE) begin
               r.status = STATUS_ERROR;
            end else begin
               if (int'(w.new_size) < tbl_limit) begin
                  shrink = tbl_limit - int'(w.new_size);
                  while (shrink > room && live_cnt != 0) drop_oldest();
                  room = (shrink <= room) ? room - shrink : 0;
               end else begin
                  room += int'(w.new_size) - tbl_limit;
               end
               tbl_limit = int'(w.new_size);
            end
         end
         REQ_READ_BYTE: begin
            r.read_data = store_bytes[w.read_addr];
         end
         default: begin
            r.status = STATUS_ERROR;
         end
      endcase
      r.entry_count = 8'(live_cnt);
      r.free_bytes  = 13'(room);
      return r;
   endfunction

   function automatic hdt_req_type mk_req(input logic [2:0] kind, input int idx,
                                          input int nonly, input int nlen, input int vlen,
                                          input int dbyte, input int nsize, input int raddr);
      hdt_req_type w;
      w.req_type     = kind;
      w.hpack_index  = 8'(idx);
      w.skip_value   = 1'(nonly);
      w.name_length  = 16'(nlen);
      w.value_length = 16'(vlen);
      w.data_byte    = 8'(dbyte);
      w.new_size     = 16'(nsize);
      w.read_addr    = 12'(raddr);
      return w;
   endfunction

   function automatic hdt_rsp_type mk_rsp(input logic [1:0] status, input logic [1:0] hit,
                                          input int sidx, input int count, input int free_b);
      hdt_rsp_type r;
      r = '0;
      r.status       = status;
      r.hit_kind     = hit;
      r.static_index = 6'(sidx);
      r.entry_count  = 8'(count);
      r.free_bytes   = 13'(free_b);
      return r;
   endfunction

   function automatic void put_row(input hdt_req_type w, input bit typed, input hdt_rsp_type r);
      stim_row_type row;
      row.word  = w;
      row.typed = typed;
      row.rsp   = r;
      directed_rows.push_back(row);
   endfunction

   function automatic hdt_req_type pick_word();
      hdt_req_type w;
      logic [95:0] noise;
      int roll;
      int nlen;
      int vlen;
      noise = {$urandom, $urandom, $urandom};
      w = noise[79:0];
      roll = $urandom_range(99);
      if (bytes_to_send > 0 && roll < 93) begin
         w.req_type = REQ_ADD_DATA;
         bytes_to_send--;
         return w;
      end
      roll = $urandom_range(99);
      if (roll < 35) begin
         w.req_type = REQ_ADD_BEGIN;
         roll = $urandom_range(99);
         if (roll < 85) begin
            nlen = $urandom_range(1, 16);
            vlen = $urandom_range(0, 48);
            bytes_to_send = nlen + vlen;
         end else if (roll < 93) begin
            // big entry, abandoned after a few bytes
            nlen = $urandom_range(256, 2047);
            vlen = $urandom_range(0, 2047);
            bytes_to_send = $urandom_range(0, 4);
         end else begin
            nlen = int'(w.name_length);
            vlen = int'(w.value_length);
            bytes_to_send = $urandom_range(0, 4);
         end
         w.name_length  = 16'(nlen);
         w.value_length = 16'(vlen);
      end else if (roll < 65) begin
         w.req_type = REQ_LOOKUP;
         roll = $urandom_range(99);
         if (roll < 60) begin
            w.hpack_index = 8'(IDX_FIRST_DYN + $urandom_range(live_cnt));
         end else if (roll < 80) begin
            w.hpack_index = 8'($urandom_range(1, STATIC_COUNT));
         end
      end else if (roll < 80 && known_addrs.size() != 0) begin
         w.req_type  = REQ_READ_BYTE;
         w.read_addr = 12'(known_addrs[$urandom_range(known_addrs.size() - 1)]);
      end else if (roll < 88) begin
         w.req_type = REQ_SIZE_UPD;
         roll = $urandom_range(99);
         if (roll < 70) begin
            w.new_size = 16'($urandom_range(1024, STORE));
         end else if (roll < 85) begin
            w.new_size = 16'($urandom_range(0, 300));
         end else begin
            w.new_size = 16'($urandom_range(STORE + 1, 65535));
         end
      end else if (roll < 94) begin
         w.req_type = REQ_ADD_DATA;
         if (bytes_to_send > 0) bytes_to_send--;
      end else begin
         w.req_type = 3'($urandom_range(REQ_RSVD_5, REQ_RSVD_7));
      end
      return w;
   endfunction

   task automatic drive_word(input hdt_req_type w, input bit typed, input hdt_rsp_type trsp);
      while (idle_on && $urandom_range(99) < 11) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start     <= 1'b1;
      req_word  <= w;
      row_typed <= typed;
      row_rsp   <= trsp;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic check_field(input string fname, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t mismatch on %s: expected %0d, actual %0d", $time, fname, want, got);
         fail_count++;
      end
   endtask

   task automatic check_rsp(input hdt_rsp_type want, input hdt_rsp_type got);
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("hit_kind", 32'(want.hit_kind), 32'(got.hit_kind));
      check_field("static_index", 32'(want.static_index), 32'(got.static_index));
      check_field("name_offset", 32'(want.name_offset), 32'(got.name_offset));
      check_field("name_len_out", 32'(want.name_len_out), 32'(got.name_len_out));
      check_field("value_offset", 32'(want.value_offset), 32'(got.value_offset));
      check_field("value_len_out", 32'(want.value_len_out), 32'(got.value_len_out));
      check_field("read_data", 32'(want.read_data), 32'(got.read_data));
      check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
      check_field("free_bytes", 32'(want.free_bytes), 32'(got.free_bytes));
   endtask

   always @(posedge clock) begin : monitor
      hdt_rsp_type predicted;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_rsp_words.size() == 0) begin
               $display("%0t response word with none expected: expected nothing, actual %h",
                        $time, rsp_word);
               fail_count++;
            end else begin
               check_rsp(expected_rsp_words.pop_front(), rsp_word);
            end
         end
         if (start && !busy) begin
            predicted = apply_to_table(req_word);
            expected_rsp_words.push_back(row_typed ? row_rsp : predicted);
            words_accepted++;
            if (predicted.hit_kind == HIT_DYNAMIC) dyn_hits++;
            if (predicted.status == STATUS_DECLINED) declined_adds++;
            if (predicted.status == STATUS_ERROR) error_rsps++;
            if (live_cnt > peak_live) peak_live = live_cnt;
         end
      end
   end

   initial begin : stimulus
      hdt_rsp_type no_rsp;
      hdt_req_type w;
      int n;
      no_rsp    = '0;
      reset     = 1'b1;
      start     = 1'b0;
      req_word  = '0;
      row_typed = 1'b0;
      row_rsp   = '0;
      idle_on   = 1'b1;

      put_row(mk_req(REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 0), 1,
              mk_rsp(STATUS_ERROR, HIT_NONE, 0, 0, STORE));
      put_row(mk_req(REQ_LOOKUP, 1, 0, 0, 0, 0, 0, 0), 1,
              mk_rsp(STATUS_OK, HIT_STATIC, 0, 0, STORE));
      put_row(mk_req(REQ_LOOKUP, STATIC_COUNT, 0, 0, 0, 0, 0, 0), 1,
              mk_rsp(STATUS_OK, HIT_STATIC, STATIC_COUNT - 1, 0, STORE));
      put_row(mk_req(REQ_LOOKUP, IDX_FIRST_DYN, 0, 0, 0, 0, 0, 0), 1,
              mk_rsp(STATUS_ERROR, HIT_NONE, 0, 0, STORE));
      put_row(mk_req(REQ_LOOKUP, 255, 1, 0, 0, 0, 0, 0), 1,
              mk_rsp(STATUS_ERROR, HIT_NONE, 0, 0, STORE));
      put_row(mk_req(REQ_ADD_DATA, 0, 0, 0, 0, 8'hA5, 0, 0), 1,
              mk_rsp(STATUS_ERROR, HIT_NONE, 0, 0, STORE));
      put_row(mk_req(REQ_RSVD_5, 0, 0, 0, 0, 0, 0, 0), 1,
              mk_rsp(STATUS_ERROR, HIT_NONE, 0, 0, STORE));
      put_row(mk_req(REQ_RSVD_6, 0, 0, 0, 0, 0, 0, 0), 1,
              mk_rsp(STATUS_ERROR, HIT_NONE, 0, 0, STORE));
      put_row(mk_req(REQ_RSVD_7, 0, 0, 0, 0, 0, 0, 0), 1,
              mk_rsp(STATUS_ERROR, HIT_NONE, 0, 0, STORE));
      put_row(mk_req(REQ_SIZE_UPD, 0, 0, 0, 0, 0, STORE + 1, 0), 1,
              mk_rsp(STATUS_ERROR, HIT_NONE, 0, 0, STORE));
      put_row(mk_req(REQ_SIZE_UPD, 0, 0, 0, 0, 0, 65535, 0), 1,
              mk_rsp(STATUS_ERROR, HIT_NONE, 0, 0, STORE));
      put_row(mk_req(REQ_ADD_BEGIN, 0, 0, STORE - ENTRY_OVERHEAD + 1, 0, 0, 0, 0), 1,
              mk_rsp(STATUS_DECLINED, HIT_NONE, 0, 0, STORE));
      put_row(mk_req(REQ_ADD_DATA, 0, 0, 0, 0, 8'h00, 0, 0), 0, no_rsp);
      put_row(mk_req(REQ_ADD_BEGIN, 0, 0, 3, 2, 0, 0, 0), 0, no_rsp);
      put_row(mk_req(REQ_ADD_DATA, 0, 0, 0, 0, 8'h00, 0, 0), 0, no_rsp);
      put_row(mk_req(REQ_ADD_DATA, 0, 0, 0, 0, 8'hFF, 0, 0), 0, no_rsp);
      put_row(mk_req(REQ_ADD_DATA, 0, 0, 0, 0, 8'h5A, 0, 0), 0, no_rsp);
      put_row(mk_req(REQ_ADD_DATA, 0, 0, 0, 0, 8'hA5, 0, 0), 0, no_rsp);
      put_row(mk_req(REQ_ADD_DATA, 0, 0, 0, 0, 8'h01, 0, 0), 0, no_rsp);
      put_row(mk_req(REQ_LOOKUP, IDX_FIRST_DYN, 0, 0, 0, 0, 0, 0), 0, no_rsp);
      put_row(mk_req(REQ_LOOKUP, IDX_FIRST_DYN, 1, 0, 0, 0, 0, 0), 0, no_rsp);
      put_row(mk_req(REQ_READ_BYTE, 0, 0, 0, 0, 0, 0, 0), 0, no_rsp);
      put_row(mk_req(REQ_READ_BYTE, 0, 0, 0, 0, 0, 0, 4), 0, no_rsp);
      put_row(mk_req(REQ_ADD_BEGIN, 0, 0, 0, 0, 0, 0, 0), 0, no_rsp);
      put_row(mk_req(REQ_LOOKUP, IDX_FIRST_DYN + 1, 0, 0, 0, 0, 0, 0), 0, no_rsp);
      put_row(mk_req(REQ_ADD_BEGIN, 0, 0, 0, STORE - ENTRY_OVERHEAD, 0, 0, 0), 0, no_rsp);
      put_row(mk_req(REQ_ADD_BEGIN, 0, 0, 1, 0, 0, 0, 0), 0, no_rsp);
      put_row(mk_req(REQ_SIZE_UPD, 0, 0, 0, 0, 0, 0, 0), 1,
              mk_rsp(STATUS_OK, HIT_NONE, 0, 0, 0));
      put_row(mk_req(REQ_SIZE_UPD, 0, 0, 0, 0, 0, STORE, 0), 1,
              mk_rsp(STATUS_OK, HIT_NONE, 0, 0, STORE));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         drive_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].rsp);
      end

      for (n = 0; n < 300; n++) begin
         idle_on = !(n >= 120 && n < 260);
         drive_word(pick_word(), 1'b0, no_rsp);
      end

      // fill the descriptor ring with zero-length entries
      idle_on = 1'b1;
      bytes_to_send = 0;
      drive_word(mk_req(REQ_SIZE_UPD, 0, 0, 0, 0, 0, STORE, 0), 1'b0, no_rsp);
      for (n = 0; n < 170; n++) begin
         if ($urandom_range(99) < 85) begin
            w = mk_req(REQ_ADD_BEGIN, 0, 0, 0, 0, 0, 0, 0);
         end else begin
            w = mk_req(REQ_LOOKUP, IDX_FIRST_DYN + $urandom_range(live_cnt),
                       $urandom_range(1), 0, 0, 0, 0, 0);
         end
         drive_word(w, 1'b0, no_rsp);
      end

      for (n = 0; n < 280; n++) begin
         drive_word(pick_word(), 1'b0, no_rsp);
      end
      start <= 1'b0;

      while (expected_rsp_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d request words: %0d dynamic hits, %0d declined adds,",
               words_accepted, dyn_hits, declined_adds);
      $display("%0d error responses, %0d evictions, up to %0d live entries.",
               error_rsps, evictions, peak_live);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin : watchdog
      #12_000_000;
      $display("%0t timeout: response words still outstanding", $time);
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== hpack_dynamic_table_core.f =====
design/hdt_pkg.sv
design/hdt_ram.sv
design/hpack_dynamic_table_core.sv
tb/tb_top.sv
